/* rtl/binned_2d_table_lookup_unit_assert.svh */
// Assertion macros shared by the lookup unit RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef BINNED_2D_TABLE_LOOKUP_UNIT_ASSERT_SVH
`define BINNED_2D_TABLE_LOOKUP_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define B2TL_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define B2TL_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`else

`define B2TL_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define B2TL_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

/* rtl/b2tl_pkg.sv */
package b2tl_pkg;

  // parameter defaults
  localparam int MAX_ENERGY_BINS_DEF = 64;
  localparam int MAX_ANGLE_BINS_DEF  = 32;
  localparam int COORD_WIDTH_DEF     = 16;
  localparam int WORD_WIDTH_DEF      = 32;

  // fixed field widths
  localparam int CMD_W    = 2;
  localparam int SLOT_W   = 7;
  localparam int EIDX_W   = 6;
  localparam int AIDX_W   = 5;
  localparam int EBIN_W   = 6;
  localparam int ABIN_W   = 5;

  // configuration registers
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_EBC_W  = 7;
  localparam int CFG_ABC_W  = 6;
  localparam logic [CFG_EBC_W-1:0] CFG_EBC_RESET = 7'd64;
  localparam logic [CFG_ABC_W-1:0] CFG_ABC_RESET = 6'd32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENERGY_BIN_COUNT = 1'b0,
    CFG_ANGLE_BIN_COUNT  = 1'b1
  } cfg_reg_e;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_ENERGY = 2'd0,
    CMD_LOAD_ANGLE  = 2'd1,
    CMD_WRITE_TABLE = 2'd2,
    CMD_LOOKUP      = 2'd3
  } cmd_e;

  // top -> bin search
  typedef struct packed {
    logic start;
    logic load_energy;
    logic load_angle;
  } search_ctl_t;

  // bin search -> top
  typedef struct packed {
    logic busy;
    logic done;
    logic clamped;
  } search_sts_t;

endpackage

/* rtl/b2tl_bin_search.sv */
`include "binned_2d_table_lookup_unit_assert.svh"

// Edge stores plus a single shared signed comparator stepped over the edges.
module b2tl_bin_search #(
  parameter int MAX_ENERGY_BINS = b2tl_pkg::MAX_ENERGY_BINS_DEF,
  parameter int MAX_ANGLE_BINS  = b2tl_pkg::MAX_ANGLE_BINS_DEF,
  parameter int COORD_WIDTH     = b2tl_pkg::COORD_WIDTH_DEF,
  localparam int NW  = $clog2(MAX_ENERGY_BINS + 1),
  localparam int MW  = $clog2(MAX_ANGLE_BINS + 1),
  localparam int CLW = $clog2(MAX_ENERGY_BINS),
  localparam int RW  = (MAX_ANGLE_BINS > 1) ? $clog2(MAX_ANGLE_BINS) : 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  b2tl_pkg::search_ctl_t             ctl_i,
  input  logic [b2tl_pkg::SLOT_W-1:0]       slot_i,
  input  logic signed [COORD_WIDTH-1:0]     edge_value_i,
  input  logic signed [COORD_WIDTH-1:0]     log_energy_i,
  input  logic signed [COORD_WIDTH-1:0]     cos_angle_i,
  input  logic [NW-1:0]                     n_i,
  input  logic [MW-1:0]                     m_i,
  output b2tl_pkg::search_sts_t             sts_o,
  output logic [CLW-1:0]                    col_o,
  output logic [RW-1:0]                     row_o
);

  localparam int IXW = $clog2(MAX_ENERGY_BINS + 2);
  localparam int IYW = $clog2(MAX_ANGLE_BINS + 2);
  localparam int XW  = COORD_WIDTH + 1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MID1  = 6'b000010,
    S_MID2  = 6'b000100,
    S_ESCAN = 6'b001000,
    S_ASCAN = 6'b010000,
    S_FIN   = 6'b100000
  } state_e;

  state_e                     state_q, state_d;
  logic [NW-1:0]              e_idx_q, e_idx_d;
  logic [MW-1:0]              a_idx_q, a_idx_d;
  logic [IXW-1:0]             ix_q, ix_d;
  logic [IYW-1:0]             iy_q, iy_d;
  logic [NW-1:0]              n_q, n_d;
  logic [MW-1:0]              m_q, m_d;
  logic signed [XW-1:0]       x2_q, x2_d;
  logic signed [COORD_WIDTH-1:0] c_q, c_d;
  logic signed [COORD_WIDTH-1:0] e1_q, e1_d;

  logic signed [COORD_WIDTH-1:0] e_mem [MAX_ENERGY_BINS+1];
  logic signed [COORD_WIDTH-1:0] a_mem [MAX_ANGLE_BINS+1];
  logic signed [COORD_WIDTH-1:0] e_rdata_q;
  logic signed [COORD_WIDTH-1:0] a_rdata_q;

  logic signed [XW-1:0]       cmp_a, cmp_b, mid2;
  logic                       cmp_le;
  logic                       clamped;

  // edge stores: one write port, one registered read port each
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_energy && (32'(slot_i) <= 32'(MAX_ENERGY_BINS))) begin
      e_mem[NW'(slot_i)] <= edge_value_i;
    end
    if (ctl_i.load_angle && (32'(slot_i) <= 32'(MAX_ANGLE_BINS))) begin
      a_mem[MW'(slot_i)] <= edge_value_i;
    end
    e_rdata_q <= e_mem[e_idx_d];
    a_rdata_q <= a_mem[a_idx_d];
  end

  assign mid2 = XW'(e1_q) + XW'(e_rdata_q);

  // shared comparator, operands picked by phase
  always_comb begin
    cmp_a = x2_q;
    cmp_b = mid2;
    case (state_q)
      S_ESCAN: begin
        cmp_a = $signed({e_rdata_q, 1'b0});
        cmp_b = x2_q;
      end
      S_ASCAN: begin
        cmp_a = XW'(a_rdata_q);
        cmp_b = XW'(c_q);
      end
      default: begin
        cmp_a = x2_q;
        cmp_b = mid2;
      end
    endcase
  end

  assign cmp_le = (cmp_a <= cmp_b);

  always_comb begin
    state_d = state_q;
    e_idx_d = e_idx_q;
    a_idx_d = a_idx_q;
    ix_d    = ix_q;
    iy_d    = iy_q;
    n_d     = n_q;
    m_d     = m_q;
    x2_d    = x2_q;
    c_d     = c_q;
    e1_d    = e1_q;
    case (state_q)
      S_IDLE: begin
        if (ctl_i.start) begin
          e_idx_d = NW'(1);
          x2_d    = $signed({log_energy_i, 1'b0});
          c_d     = cos_angle_i;
          n_d     = n_i;
          m_d     = m_i;
          ix_d    = '0;
          iy_d    = '0;
          state_d = S_MID1;
        end
      end
      S_MID1: begin
        e1_d    = e_rdata_q;
        e_idx_d = NW'(2);
        state_d = S_MID2;
      end
      S_MID2: begin
        // energies at or below the mid of edges 1 and 2 snap to it
        if (cmp_le) begin
          x2_d = mid2;
        end
        e_idx_d = '0;
        state_d = S_ESCAN;
      end
      S_ESCAN: begin
        if (cmp_le) begin
          ix_d = ix_q + IXW'(1);
        end
        if (e_idx_q == n_q) begin
          a_idx_d = '0;
          state_d = S_ASCAN;
        end else begin
          e_idx_d = e_idx_q + NW'(1);
        end
      end
      S_ASCAN: begin
        if (cmp_le) begin
          iy_d = iy_q + IYW'(1);
        end
        if (a_idx_q == m_q) begin
          state_d = S_FIN;
        end else begin
          a_idx_d = a_idx_q + MW'(1);
        end
      end
      S_FIN: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      e_idx_q <= '0;
      a_idx_q <= '0;
      ix_q    <= '0;
      iy_q    <= '0;
      n_q     <= '0;
      m_q     <= '0;
    end else begin
      state_q <= state_d;
      e_idx_q <= e_idx_d;
      a_idx_q <= a_idx_d;
      ix_q    <= ix_d;
      iy_q    <= iy_d;
      n_q     <= n_d;
      m_q     <= m_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x2_q <= x2_d;
    c_q  <= c_d;
    e1_q <= e1_d;
  end

  // count -> bin: past the last edge gives last column, zero gives column 0
  always_comb begin
    if (ix_q == '0) begin
      col_o = '0;
    end else if (ix_q > IXW'(n_q)) begin
      col_o = CLW'(n_q - NW'(1));
    end else begin
      col_o = CLW'(ix_q - IXW'(1));
    end
  end

  assign clamped = (iy_q > IYW'(m_q));

  always_comb begin
    if (clamped) begin
      row_o = RW'(m_q - MW'(1));
    end else if (iy_q == '0) begin
      row_o = '0;
    end else begin
      row_o = RW'(iy_q - IYW'(1));
    end
  end

  assign sts_o.busy    = (state_q != S_IDLE);
  assign sts_o.done    = (state_q == S_FIN);
  assign sts_o.clamped = clamped;

  `B2TL_ASSERT_IMP(a_escan_in_range, clk_i, rst_ni, state_q == S_ESCAN, e_idx_q <= n_q, "energy scan past n")
  `B2TL_ASSERT_IMP(a_ascan_in_range, clk_i, rst_ni, state_q == S_ASCAN, a_idx_q <= m_q, "angle scan past m")
  `B2TL_ASSERT_IMP(a_ecount_bound, clk_i, rst_ni, state_q == S_ASCAN, ix_q <= (IXW'(n_q) + IXW'(1)), "energy count overflow")
  `B2TL_ASSERT_NXT(a_done_to_idle, clk_i, rst_ni, sts_o.done, !sts_o.busy, "search did not return to idle")

endmodule

/* rtl/binned_2d_table_lookup_unit.sv */
// Binned 2D table lookup. Each input transaction carries a command in tuser:
// load an energy edge, load an angle edge, write a table entry, or look up.
// A lookup counts the energy edges 0..n at or below the key (the key is first
// raised to the midpoint of edges 1 and 2) and the angle edges 0..m at or
// below the angle, and returns the table word at row*n + column with the
// chosen bins; an angle at or above the top edge is clamped to row m-1 and
// flagged in tuser. Every transaction gives exactly one result; non-lookup
// commands return all zeros. n and m come from the two config registers,
// saturated to 2..MAX_ENERGY_BINS and 1..MAX_ANGLE_BINS. Timing: s_axis_tready
// is low while a transaction is being worked on. A lookup runs the bin search,
// in which the single comparator steps through one stored edge per cycle, and
// then reads the table; lookups and table writes both register the row*n
// multiply before the table port. A new transaction is accepted while the
// previous result still waits in the output register. Edge and table stores
// have no reset; only written entries may be looked up. Config writes are
// taken any cycle but must only happen when idle.
module binned_2d_table_lookup_unit #(
  parameter int MAX_ENERGY_BINS = b2tl_pkg::MAX_ENERGY_BINS_DEF,
  parameter int MAX_ANGLE_BINS  = b2tl_pkg::MAX_ANGLE_BINS_DEF,
  parameter int COORD_WIDTH     = b2tl_pkg::COORD_WIDTH_DEF,
  parameter int WORD_WIDTH      = b2tl_pkg::WORD_WIDTH_DEF,
  // slave tdata layout
  localparam int OFS_SLOT = 0,
  localparam int OFS_EV   = OFS_SLOT + b2tl_pkg::SLOT_W,
  localparam int OFS_EI   = OFS_EV + COORD_WIDTH,
  localparam int OFS_AI   = OFS_EI + b2tl_pkg::EIDX_W,
  localparam int OFS_DW   = OFS_AI + b2tl_pkg::AIDX_W,
  localparam int OFS_LE   = OFS_DW + WORD_WIDTH,
  localparam int OFS_CA   = OFS_LE + COORD_WIDTH,
  localparam int IN_FIELDS_W  = OFS_CA + COORD_WIDTH,
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8,
  localparam int OUT_FIELDS_W = WORD_WIDTH + b2tl_pkg::EBIN_W + b2tl_pkg::ABIN_W,
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // config write port
  input  logic                                 cfg_we_i,
  input  logic [b2tl_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [b2tl_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // command stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // edge_slot, edge_value, energy_index, angle_index, data_word, log_energy,
  // cos_angle, zero pad
  input  logic [IN_TDATA_W-1:0]                s_axis_tdata,
  // cmd
  input  logic [b2tl_pkg::CMD_W-1:0]           s_axis_tuser,
  // result stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // table_word, energy_bin, angle_bin, zero pad
  output logic [OUT_TDATA_W-1:0]               m_axis_tdata,
  // status (angle clamped)
  output logic                                 m_axis_tuser
);

  localparam int NW  = $clog2(MAX_ENERGY_BINS + 1);
  localparam int MW  = $clog2(MAX_ANGLE_BINS + 1);
  localparam int CLW = $clog2(MAX_ENERGY_BINS);
  localparam int RW  = (MAX_ANGLE_BINS > 1) ? $clog2(MAX_ANGLE_BINS) : 1;
  localparam int AMW = (RW > b2tl_pkg::AIDX_W) ? RW : b2tl_pkg::AIDX_W;
  localparam int PW  = AMW + NW + 1;
  localparam int TABLE_DEPTH = MAX_ENERGY_BINS * MAX_ANGLE_BINS;
  localparam int TAW = $clog2(TABLE_DEPTH);

  typedef enum logic [5:0] {
    T_IDLE   = 6'b000001,
    T_WAIT   = 6'b000010,
    T_MUL    = 6'b000100,
    T_WRITE  = 6'b001000,
    T_READ   = 6'b010000,
    T_RESULT = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // config registers
  logic [b2tl_pkg::CFG_EBC_W-1:0] ebc_q;
  logic [b2tl_pkg::CFG_ABC_W-1:0] abc_q;
  logic [NW-1:0]                  n_w;
  logic [MW-1:0]                  m_w;

  // unpacked slave fields
  logic [b2tl_pkg::CMD_W-1:0]     in_cmd;
  logic [b2tl_pkg::SLOT_W-1:0]    in_slot;
  logic signed [COORD_WIDTH-1:0]  in_edge_value;
  logic [b2tl_pkg::EIDX_W-1:0]    in_energy_index;
  logic [b2tl_pkg::AIDX_W-1:0]    in_angle_index;
  logic [WORD_WIDTH-1:0]          in_data_word;
  logic signed [COORD_WIDTH-1:0]  in_log_energy;
  logic signed [COORD_WIDTH-1:0]  in_cos_angle;
  logic                           in_fire;

  // held item
  logic [b2tl_pkg::CMD_W-1:0]     cmd_q;
  logic [b2tl_pkg::EIDX_W-1:0]    ei_q;
  logic [b2tl_pkg::AIDX_W-1:0]    ai_q;
  logic [WORD_WIDTH-1:0]          dw_q;
  logic                           is_lookup;

  // search results
  b2tl_pkg::search_ctl_t          srch_ctl;
  b2tl_pkg::search_sts_t          srch_sts;
  logic [CLW-1:0]                 srch_col;
  logic [RW-1:0]                  srch_row;
  logic [CLW-1:0]                 col_q;
  logic [RW-1:0]                  row_q;
  logic                           clamp_q;

  // table address, store and port
  logic [AMW-1:0]                 mul_a;
  logic [CLW+b2tl_pkg::EIDX_W-1:0] mul_add;
  logic [PW-1:0]                  pos_q, pos_d;
  logic                           pos_in_range;
  logic                           tbl_we;
  logic [WORD_WIDTH-1:0]          tbl_mem [TABLE_DEPTH];
  logic [WORD_WIDTH-1:0]          tbl_rdata_q;

  // output register
  logic                           out_valid_q;
  logic                           out_load;
  logic [WORD_WIDTH-1:0]          out_word_q;
  logic [b2tl_pkg::EBIN_W-1:0]    out_ebin_q;
  logic [b2tl_pkg::ABIN_W-1:0]    out_abin_q;
  logic                           out_status_q;

  assign in_cmd          = s_axis_tuser;
  assign in_slot         = s_axis_tdata[OFS_SLOT +: b2tl_pkg::SLOT_W];
  assign in_edge_value   = s_axis_tdata[OFS_EV +: COORD_WIDTH];
  assign in_energy_index = s_axis_tdata[OFS_EI +: b2tl_pkg::EIDX_W];
  assign in_angle_index  = s_axis_tdata[OFS_AI +: b2tl_pkg::AIDX_W];
  assign in_data_word    = s_axis_tdata[OFS_DW +: WORD_WIDTH];
  assign in_log_energy   = s_axis_tdata[OFS_LE +: COORD_WIDTH];
  assign in_cos_angle    = s_axis_tdata[OFS_CA +: COORD_WIDTH];

  assign s_axis_tready = (state_q == T_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign is_lookup     = (cmd_q == b2tl_pkg::CMD_LOOKUP);

  // config port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ebc_q <= b2tl_pkg::CFG_EBC_RESET;
      abc_q <= b2tl_pkg::CFG_ABC_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        b2tl_pkg::CFG_ENERGY_BIN_COUNT: begin
          ebc_q <= cfg_data_i[b2tl_pkg::CFG_EBC_W-1:0];
        end
        b2tl_pkg::CFG_ANGLE_BIN_COUNT: begin
          abc_q <= cfg_data_i[b2tl_pkg::CFG_ABC_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // saturate bin counts into the supported range
  always_comb begin
    if (32'(ebc_q) < 32'(2)) begin
      n_w = NW'(2);
    end else if (32'(ebc_q) > 32'(MAX_ENERGY_BINS)) begin
      n_w = NW'(MAX_ENERGY_BINS);
    end else begin
      n_w = NW'(ebc_q);
    end
    if (32'(abc_q) < 32'(1)) begin
      m_w = MW'(1);
    end else if (32'(abc_q) > 32'(MAX_ANGLE_BINS)) begin
      m_w = MW'(MAX_ANGLE_BINS);
    end else begin
      m_w = MW'(abc_q);
    end
  end

  // edge loads go straight to the search unit on accept
  assign srch_ctl.start       = in_fire && (in_cmd == b2tl_pkg::CMD_LOOKUP);
  assign srch_ctl.load_energy = in_fire && (in_cmd == b2tl_pkg::CMD_LOAD_ENERGY);
  assign srch_ctl.load_angle  = in_fire && (in_cmd == b2tl_pkg::CMD_LOAD_ANGLE);

  b2tl_bin_search #(
    .MAX_ENERGY_BINS (MAX_ENERGY_BINS),
    .MAX_ANGLE_BINS  (MAX_ANGLE_BINS),
    .COORD_WIDTH     (COORD_WIDTH)
  ) u_search (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (srch_ctl),
    .slot_i       (in_slot),
    .edge_value_i (in_edge_value),
    .log_energy_i (in_log_energy),
    .cos_angle_i  (in_cos_angle),
    .n_i          (n_w),
    .m_i          (m_w),
    .sts_o        (srch_sts),
    .col_o        (srch_col),
    .row_o        (srch_row)
  );

  // one multiplier serves table writes and lookups: row * n + column
  assign mul_a   = is_lookup ? AMW'(row_q) : AMW'(ai_q);
  assign mul_add = is_lookup ? (CLW+b2tl_pkg::EIDX_W)'(col_q)
                             : (CLW+b2tl_pkg::EIDX_W)'(ei_q);
  assign pos_d   = PW'(PW'(mul_a) * PW'(n_w)) + PW'(mul_add);

  // writes past the table are dropped
  assign pos_in_range = (32'(pos_q) < 32'(TABLE_DEPTH));
  assign tbl_we       = (state_q == T_WRITE) && pos_in_range;

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[pos_q[TAW-1:0]] <= dw_q;
    end
    tbl_rdata_q <= tbl_mem[pos_q[TAW-1:0]];
  end

  assign out_load = (state_q == T_RESULT) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      T_IDLE: begin
        if (in_fire) begin
          case (in_cmd)
            b2tl_pkg::CMD_LOOKUP:      state_d = T_WAIT;
            b2tl_pkg::CMD_WRITE_TABLE: state_d = T_MUL;
            default:                   state_d = T_RESULT;
          endcase
        end
      end
      T_WAIT: begin
        if (srch_sts.done) begin
          state_d = T_MUL;
        end
      end
      T_MUL: begin
        state_d = is_lookup ? T_READ : T_WRITE;
      end
      T_WRITE: begin
        state_d = T_RESULT;
      end
      T_READ: begin
        state_d = T_RESULT;
      end
      T_RESULT: begin
        if (out_load) begin
          state_d = T_IDLE;
        end
      end
      default: begin
        state_d = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      out_valid_q <= 1'b0;
      cmd_q       <= b2tl_pkg::CMD_LOAD_ENERGY;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        cmd_q <= in_cmd;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ei_q <= in_energy_index;
      ai_q <= in_angle_index;
      dw_q <= in_data_word;
    end
    if ((state_q == T_WAIT) && srch_sts.done) begin
      col_q   <= srch_col;
      row_q   <= srch_row;
      clamp_q <= srch_sts.clamped;
    end
    if (state_q == T_MUL) begin
      pos_q <= pos_d;
    end
    if (out_load) begin
      if (is_lookup) begin
        out_word_q   <= tbl_rdata_q;
        out_ebin_q   <= b2tl_pkg::EBIN_W'(col_q);
        out_abin_q   <= b2tl_pkg::ABIN_W'(row_q);
        out_status_q <= clamp_q;
      end else begin
        out_word_q   <= '0;
        out_ebin_q   <= '0;
        out_abin_q   <= '0;
        out_status_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_abin_q, out_ebin_q, out_word_q});
  assign m_axis_tuser  = out_status_q;

  `B2TL_ASSERT_IMP(a_accept_search_idle, clk_i, rst_ni, s_axis_tready, !srch_sts.busy, "accepting while search busy")
  `B2TL_ASSERT_IMP(a_done_while_wait, clk_i, rst_ni, srch_sts.done, state_q == T_WAIT, "search done outside wait")
  `B2TL_ASSERT_IMP(a_write_in_table, clk_i, rst_ni, tbl_we, 32'(pos_q) < 32'(TABLE_DEPTH), "table write out of range")
  `B2TL_ASSERT_NXT(a_result_holds, clk_i, rst_ni, (state_q == T_RESULT) && out_valid_q && !m_axis_tready, state_q == T_RESULT, "result dropped under stall")

endmodule
